/* rtl/rwc_pkg.sv */
// Shared constants and request/result types for the ROM window checksum block.
package rwc_pkg;

   localparam int unsigned WINDOW_WORDS = 262144;
   localparam int unsigned COUNT_W      = $clog2(WINDOW_WORDS + 1);

   localparam logic [31:0] SEED_RESET = 32'hF8CA4DDC;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } rwc_req_type;

   typedef struct packed {
      logic [31:0] checksum_hi;
      logic [31:0] checksum_lo;
   } rwc_rsp_type;

endpackage

/* rtl/rom_window_checksum.sv */
// Top level of the ROM window checksum: accumulators, padding multiply and result register.

// Takes one ROM word per cycle with no gaps, for any mix of last and non-last
// words. Each word goes into an input register and is folded into the five
// accumulators in the next cycle; a word marked last also hands a snapshot of
// the accumulators to a two-stage finish path (padding multiply, then the
// final fold) and the accumulators re-seed in that same cycle, so the next
// image's first word can follow straight on. A result passes from the input
// register through the snapshot, padding-product and result registers. Words
// beyond WINDOW_WORDS are ignored but a last flag on them still closes the
// image. The input only stalls when results back up through the finish path
// and a last word has to wait for it. A seed write re-seeds every accumulator
// at once and is taken in any cycle; it is meant for an idle block.
module rom_window_checksum
   import rwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  rwc_req_type req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rwc_rsp_type rsp_data,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam logic [COUNT_W-1:0] WINDOW_CNT = COUNT_W'(WINDOW_WORDS);

   function automatic logic [31:0] rotl_self(input logic [31:0] x);
      logic [63:0] dbl;
      begin
         dbl = {x, x} << x[4:0];
         return dbl[63:32];
      end
   endfunction

   // configuration
   logic [31:0] seed_ff;
   logic        csr_go;

   // input register
   logic        s0_valid_ff;
   rwc_req_type s0_req_ff;
   logic        s0_go;

   // accumulators
   logic [63:0]        wide_sum_ff,   wide_sum_in;
   logic [31:0]        xor_acc_ff,    xor_acc_in;
   logic [31:0]        rot_sum_ff,    rot_sum_in;
   logic [31:0]        select_xor_ff, select_xor_in;
   logic [31:0]        mix_sum_ff,    mix_sum_in;
   logic [COUNT_W-1:0] words_seen_ff, words_seen_in;

   // finish stage 1: snapshot
   logic               f1_valid_ff;
   logic [31:0]        f1_hi_ff;
   logic [31:0]        f1_rot_ff;
   logic [31:0]        f1_sel_ff;
   logic [31:0]        f1_mix_ff;
   logic [COUNT_W-1:0] f1_missing_ff;

   // finish stage 2: padding product
   logic                f2_valid_ff;
   logic [31:0]         f2_hi_ff;
   logic [31:0]         f2_rs_ff;
   logic [31:0]         f2_mix_ff;
   logic [31:0]         f2_prod_ff;
   logic [32+COUNT_W-1:0] pad_full;

   // result register
   logic        rsp_valid_ff;
   rwc_rsp_type rsp_data_ff;

   logic out_ready, f2_ready, f1_ready, s0_ready;

   // per-word update
   logic        in_window;
   logic [31:0] x, y;
   logic [63:0] sum_new;
   logic [31:0] rot_new;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign f2_ready  = !f2_valid_ff || out_ready;
   assign f1_ready  = !f1_valid_ff || f2_ready;
   assign s0_go     = s0_valid_ff && (!s0_req_ff.last || f1_ready);
   assign s0_ready  = !s0_valid_ff || s0_go;
   assign req_stall = !s0_ready;

   assign csr_ready = 1'b1;
   assign csr_go    = csr_valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      x         = s0_req_ff.word;
      y         = rotl_self(x);
      in_window = words_seen_ff < WINDOW_CNT;
      sum_new   = wide_sum_ff + {32'd0, x};
      rot_new   = rot_sum_ff + y;

      wide_sum_in   = wide_sum_ff;
      xor_acc_in    = xor_acc_ff;
      rot_sum_in    = rot_sum_ff;
      select_xor_in = select_xor_ff;
      mix_sum_in    = mix_sum_ff;
      words_seen_in = words_seen_ff;
      if (in_window) begin
         wide_sum_in   = sum_new;
         xor_acc_in    = xor_acc_ff ^ x;
         rot_sum_in    = rot_new;
         select_xor_in = select_xor_ff ^
                         ((select_xor_ff < x) ? (sum_new[31:0] ^ x) : y);
         mix_sum_in    = mix_sum_ff + (rot_new ^ x);
         words_seen_in = words_seen_ff + COUNT_W'(1);
      end
   end

   assign pad_full = f1_rot_ff * {32'd0, f1_missing_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         f1_valid_ff   <= 1'b0;
         f2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seed_ff       <= SEED_RESET;
         wide_sum_ff   <= {SEED_RESET, SEED_RESET};
         xor_acc_ff    <= SEED_RESET;
         rot_sum_ff    <= SEED_RESET;
         select_xor_ff <= SEED_RESET;
         mix_sum_ff    <= SEED_RESET;
         words_seen_ff <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            s0_valid_ff <= 1'b1;
         end else if (s0_go) begin
            s0_valid_ff <= 1'b0;
         end

         if (csr_go) begin
            seed_ff       <= csr_data;
            wide_sum_ff   <= {csr_data, csr_data};
            xor_acc_ff    <= csr_data;
            rot_sum_ff    <= csr_data;
            select_xor_ff <= csr_data;
            mix_sum_ff    <= csr_data;
            words_seen_ff <= '0;
         end else if (s0_go && s0_req_ff.last) begin
            wide_sum_ff   <= {seed_ff, seed_ff};
            xor_acc_ff    <= seed_ff;
            rot_sum_ff    <= seed_ff;
            select_xor_ff <= seed_ff;
            mix_sum_ff    <= seed_ff;
            words_seen_ff <= '0;
         end else if (s0_go) begin
            wide_sum_ff   <= wide_sum_in;
            xor_acc_ff    <= xor_acc_in;
            rot_sum_ff    <= rot_sum_in;
            select_xor_ff <= select_xor_in;
            mix_sum_ff    <= mix_sum_in;
            words_seen_ff <= words_seen_in;
         end

         if (s0_go && s0_req_ff.last) begin
            f1_valid_ff <= 1'b1;
         end else if (f2_ready) begin
            f1_valid_ff <= 1'b0;
         end

         if (f1_valid_ff && f2_ready) begin
            f2_valid_ff <= 1'b1;
         end else if (out_ready) begin
            f2_valid_ff <= 1'b0;
         end

         if (f2_valid_ff && out_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s0_req_ff <= req_data;
      end
      if (s0_go && s0_req_ff.last) begin
         f1_hi_ff      <= wide_sum_in[63:32] ^ wide_sum_in[31:0] ^ xor_acc_in;
         f1_rot_ff     <= rot_sum_in;
         f1_sel_ff     <= select_xor_in;
         f1_mix_ff     <= mix_sum_in;
         f1_missing_ff <= WINDOW_CNT - words_seen_in;
      end
      if (f1_valid_ff && f2_ready) begin
         f2_hi_ff   <= f1_hi_ff;
         f2_rs_ff   <= f1_rot_ff ^ f1_sel_ff;
         f2_mix_ff  <= f1_mix_ff;
         f2_prod_ff <= pad_full[31:0];
      end
      if (f2_valid_ff && out_ready) begin
         rsp_data_ff.checksum_hi <= f2_hi_ff;
         rsp_data_ff.checksum_lo <= f2_rs_ff ^ (f2_mix_ff + f2_prod_ff);
      end
   end

endmodule
